>>> hdl/c_subset_tokenizer_unit_macros.svh
// Assertion helpers shared by the tokenizer RTL.
`ifndef C_SUBSET_TOKENIZER_UNIT_MACROS_SVH
`define C_SUBSET_TOKENIZER_UNIT_MACROS_SVH

// Check a property at every rising clock edge outside reset.
`define CST_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Check that a condition implies another one in the next cycle.
`define CST_ASSERT_NEXT(label, cond, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) \
      else $error(msg);

`endif

>>> hdl/cst_pkg.sv
package cst_pkg;

   localparam int MAX_ID_LEN_DEF = 9;
   localparam int LINE_BITS_DEF  = 24;
   localparam int VALUE_BITS_DEF = 32;
   localparam int OUT_DEPTH      = 4;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       is_end;
   } req_type;

   typedef struct packed {
      logic [5:0]  token_kind;
      logic [1:0]  error_code;
      logic [31:0] const_value;
      logic [63:0] ident_low_chars;
      logic [7:0]  ident_ninth_char;
      logic [3:0]  ident_len;
      logic [23:0] line_number;
      logic        last;
   } rsp_type;

   typedef enum logic [3:0] {
      M_IDLE, M_IDENT, M_DEC, M_ZERO, M_HEX, M_CQ1, M_CQ2,
      M_SLASH, M_LCOMM, M_BCOMM, M_BSTAR, M_OP2
   } scan_mode_type;

   localparam logic [5:0] K_ID    = 6'd9;
   localparam logic [5:0] K_INT   = 6'd10;
   localparam logic [5:0] K_CHR   = 6'd11;
   localparam logic [5:0] K_PLUS  = 6'd12;
   localparam logic [5:0] K_MINUS = 6'd13;
   localparam logic [5:0] K_STAR  = 6'd14;
   localparam logic [5:0] K_SLASH = 6'd15;
   localparam logic [5:0] K_LPAR  = 6'd16;
   localparam logic [5:0] K_RPAR  = 6'd17;
   localparam logic [5:0] K_LBRC  = 6'd18;
   localparam logic [5:0] K_RBRC  = 6'd19;
   localparam logic [5:0] K_SEMI  = 6'd20;
   localparam logic [5:0] K_COMMA = 6'd21;
   localparam logic [5:0] K_ASSIGN = 6'd22;
   localparam logic [5:0] K_EQ    = 6'd23;
   localparam logic [5:0] K_NE    = 6'd24;
   localparam logic [5:0] K_GT    = 6'd25;
   localparam logic [5:0] K_GE    = 6'd26;
   localparam logic [5:0] K_LT    = 6'd27;
   localparam logic [5:0] K_LE    = 6'd28;
   localparam logic [5:0] K_AND   = 6'd29;
   localparam logic [5:0] K_OR    = 6'd30;
   localparam logic [5:0] K_END   = 6'd31;
   localparam logic [5:0] K_ERR   = 6'd32;
   localparam logic [5:0] K_NONE  = 6'd0;

   localparam logic [1:0] E_NONE  = 2'd0;
   localparam logic [1:0] E_CHAR  = 2'd1;
   localparam logic [1:0] E_LONG  = 2'd2;
   localparam logic [1:0] E_QUOTE = 2'd3;

   localparam int KW_COUNT = 9;
   // Keyword text, first character in the low byte, zero padded.
   localparam logic [63:0] KW_TEXT [KW_COUNT] = '{
      64'h0000_0000_7261_6863, 64'h0000_0000_6573_6c65, 64'h0000_0000_0000_6669,
      64'h0000_0000_0074_6e69, 64'h0000_0000_6e69_616d, 64'h0074_6e69_6461_6572,
      64'h0000_0000_6469_6f76, 64'h0000_0065_6c69_6877, 64'h746e_6965_7469_7277
   };
   localparam logic [3:0] KW_LEN [KW_COUNT] = '{
      4'd4, 4'd4, 4'd2, 4'd3, 4'd4, 4'd7, 4'd4, 4'd5, 4'd8
   };

   function automatic logic is_alpha(input logic [7:0] b);
      return (b >= 8'h61 && b <= 8'h7a) || (b >= 8'h41 && b <= 8'h5a) || b == 8'h5f;
   endfunction

   function automatic logic is_digit(input logic [7:0] b);
      return b >= 8'h30 && b <= 8'h39;
   endfunction

   function automatic logic [5:0] single_kind(input logic [7:0] b);
      logic [5:0] k;
      unique case (b)
         8'h2b:   k = K_PLUS;
         8'h2d:   k = K_MINUS;
         8'h2a:   k = K_STAR;
         8'h28:   k = K_LPAR;
         8'h29:   k = K_RPAR;
         8'h7b:   k = K_LBRC;
         8'h7d:   k = K_RBRC;
         8'h3b:   k = K_SEMI;
         8'h2c:   k = K_COMMA;
         default: k = K_NONE;
      endcase
      return k;
   endfunction

   function automatic rsp_type make_tok(input logic [5:0] kind, input logic [1:0] err,
                                        input logic [31:0] val, input logic [23:0] line);
      rsp_type t;
      t = '0;
      t.token_kind  = kind;
      t.error_code  = err;
      t.const_value = val;
      t.line_number = line;
      return t;
   endfunction

endpackage

>>> hdl/c_subset_tokenizer_unit.sv
// Byte-serial lexer for a small C subset. Each accepted request carries one source byte
// (or an end mark) and yields zero, one or two tokens on the rsp_ channel, in order, with
// last set on the final token of that request. A request is taken every cycle unless req_stall
// is high: the whole scan step is one level of logic from the scanner state registers to a
// four-entry token queue, and req_stall rises only while that queue has fewer than two free
// entries, so the sustained rate is one byte per cycle as long as the consumer drains about
// one token per byte. Tokens are registered in the queue before they reach rsp_. After an
// error token the scanner drops every request until reset.
module c_subset_tokenizer_unit
#(
   parameter int MAX_ID_LEN = cst_pkg::MAX_ID_LEN_DEF,
   parameter int LINE_BITS  = cst_pkg::LINE_BITS_DEF,
   parameter int VALUE_BITS = cst_pkg::VALUE_BITS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  cst_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output cst_pkg::rsp_type rsp_data
);
   import cst_pkg::*;
`include "c_subset_tokenizer_unit_macros.svh"

   localparam int IDX_W = (MAX_ID_LEN > 1) ? $clog2(MAX_ID_LEN) : 1;
   localparam int CNT_W = $clog2(MAX_ID_LEN + 1);
   localparam int PTR_W = $clog2(OUT_DEPTH);
   localparam int QCNT_W = $clog2(OUT_DEPTH + 1);

   // Scanner state.
   scan_mode_type         mode_ff, mode_in;
   logic [7:0]            held_ff, held_in;
   logic [7:0]            store_ff [MAX_ID_LEN];
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [VALUE_BITS-1:0] acc_ff, acc_in;
   logic [LINE_BITS-1:0]  line_ff, line_in;
   logic                  halt_ff, halt_in;

   // Token queue.
   rsp_type               q_ff [OUT_DEPTH];
   logic [PTR_W-1:0]      wr_ff, wr_in, rd_ff, rd_in;
   logic [QCNT_W-1:0]     qcnt_ff, qcnt_in;

   logic                  accept, pop;
   logic [7:0]            b;
   logic                  endf;
   logic                  st_we;
   logic [IDX_W-1:0]      st_addr;
   logic                  a_v, b_v;
   rsp_type               tok_a, tok_b, push0, push1;
   logic [1:0]            push_n;
   logic [63:0]           low8;
   logic [7:0]            ninth;
   logic [5:0]            name_kind;
   logic [23:0]           line24;
   logic [31:0]           acc32;
   logic [3:0]            hexv;
   logic                  hex_ok;

   assign accept    = req_valid && !req_stall;
   assign pop       = rsp_valid && !rsp_stall;
   assign req_stall = qcnt_ff > QCNT_W'(OUT_DEPTH - 2);
   assign rsp_valid = qcnt_ff != '0;
   assign rsp_data  = q_ff[rd_ff];

   assign b      = req_data.in_byte;
   assign endf   = req_data.is_end || b == 8'h00;
   assign line24 = 24'(line_ff);
   assign acc32  = 32'(acc_ff);

   // Assemble the held name and look it up among the keywords.
   always_comb begin
      low8  = '0;
      ninth = '0;
      for (int i = 0; i < 8; i++) begin
         if (i < MAX_ID_LEN && 32'(i) < 32'(count_ff)) begin
            low8[8*i +: 8] = store_ff[IDX_W'(i % MAX_ID_LEN)];
         end
      end
      if (MAX_ID_LEN >= 9 && 32'(count_ff) >= 9) begin
         ninth = store_ff[IDX_W'(8 % MAX_ID_LEN)];
      end
      name_kind = K_ID;
      for (int k = 0; k < KW_COUNT; k++) begin
         if (32'(count_ff) == 32'(KW_LEN[k]) && low8 == KW_TEXT[k]) begin
            name_kind = 6'(k);
         end
      end
   end

   always_comb begin
      hex_ok = 1'b1;
      hexv   = '0;
      priority if (is_digit(b)) begin
         hexv = 4'(b - 8'h30);
      end else if (b >= 8'h61 && b <= 8'h66) begin
         hexv = 4'(b - 8'h57);
      end else if (b >= 8'h41 && b <= 8'h46) begin
         hexv = 4'(b - 8'h37);
      end else begin
         hex_ok = 1'b0;
      end
   end

   // One scan step: extend or close the pending token; on a close, dispatch the byte from idle.
   always_comb begin
      logic fall;
      logic line_inc;
      logic [5:0] two;
      logic [5:0] sk;
      fall     = 1'b0;
      line_inc = 1'b0;
      two      = K_NONE;
      sk       = single_kind(b);
      a_v      = 1'b0;
      b_v      = 1'b0;
      tok_a    = '0;
      tok_b    = '0;
      mode_in  = mode_ff;
      held_in  = held_ff;
      count_in = count_ff;
      acc_in   = acc_ff;
      halt_in  = halt_ff;
      st_we    = 1'b0;
      st_addr  = '0;

      if (!halt_ff) begin
         unique case (mode_ff)
            M_IDENT: begin
               if (!endf && (is_alpha(b) || is_digit(b))) begin
                  if (32'(count_ff) >= MAX_ID_LEN) begin
                     a_v     = 1'b1;
                     tok_a   = make_tok(K_ERR, E_LONG, {24'd0, b}, line24);
                     halt_in = 1'b1;
                     mode_in = M_IDLE;
                  end else begin
                     st_we    = 1'b1;
                     st_addr  = IDX_W'(count_ff);
                     count_in = count_ff + 1'b1;
                  end
               end else begin
                  a_v   = 1'b1;
                  tok_a = make_tok(name_kind, E_NONE, '0, line24);
                  tok_a.ident_low_chars  = low8;
                  tok_a.ident_ninth_char = ninth;
                  tok_a.ident_len        = 4'(count_ff);
                  fall  = 1'b1;
               end
            end
            M_DEC: begin
               if (!endf && is_digit(b)) begin
                  acc_in = (acc_ff << 3) + (acc_ff << 1) + VALUE_BITS'(b - 8'h30);
               end else begin
                  a_v   = 1'b1;
                  tok_a = make_tok(K_INT, E_NONE, acc32, line24);
                  fall  = 1'b1;
               end
            end
            M_ZERO: begin
               priority if (!endf && (b == 8'h78 || b == 8'h58)) begin
                  mode_in = M_HEX;
               end else if (!endf && is_digit(b)) begin
                  acc_in  = VALUE_BITS'(b - 8'h30);
                  mode_in = M_DEC;
               end else begin
                  a_v   = 1'b1;
                  tok_a = make_tok(K_INT, E_NONE, '0, line24);
                  fall  = 1'b1;
               end
            end
            M_HEX: begin
               if (!endf && hex_ok) begin
                  acc_in = (acc_ff << 4) | VALUE_BITS'(hexv);
               end else begin
                  a_v   = 1'b1;
                  tok_a = make_tok(K_INT, E_NONE, acc32, line24);
                  fall  = 1'b1;
               end
            end
            M_CQ1: begin
               if (endf) begin
                  a_v     = 1'b1;
                  tok_a   = make_tok(K_ERR, E_QUOTE, '0, line24);
                  halt_in = 1'b1;
                  mode_in = M_IDLE;
               end else begin
                  held_in = b;
                  mode_in = M_CQ2;
               end
            end
            M_CQ2: begin
               a_v     = 1'b1;
               mode_in = M_IDLE;
               if (!endf && b == 8'h27) begin
                  tok_a = make_tok(K_CHR, E_NONE, {24'd0, held_ff}, line24);
               end else begin
                  tok_a   = make_tok(K_ERR, E_QUOTE, endf ? 32'd0 : {24'd0, b}, line24);
                  halt_in = 1'b1;
               end
            end
            M_SLASH: begin
               priority if (!endf && b == 8'h2f) begin
                  mode_in = M_LCOMM;
               end else if (!endf && b == 8'h2a) begin
                  mode_in = M_BCOMM;
               end else begin
                  a_v   = 1'b1;
                  tok_a = make_tok(K_SLASH, E_NONE, '0, line24);
                  fall  = 1'b1;
               end
            end
            M_LCOMM: begin
               if (endf) begin
                  fall = 1'b1;
               end else if (b == 8'h0a) begin
                  line_inc = 1'b1;
                  mode_in  = M_IDLE;
               end
            end
            M_BCOMM: begin
               if (endf) begin
                  fall = 1'b1;
               end else if (b == 8'h0a) begin
                  line_inc = 1'b1;
               end else if (b == 8'h2a) begin
                  mode_in = M_BSTAR;
               end
            end
            M_BSTAR: begin
               if (endf) begin
                  fall = 1'b1;
               end else if (b == 8'h2f) begin
                  mode_in = M_IDLE;
               end else if (b != 8'h2a) begin
                  line_inc = (b == 8'h0a);
                  mode_in  = M_BCOMM;
               end
            end
            M_OP2: begin
               if (!endf) begin
                  if (b == 8'h3d) begin
                     if (held_ff == 8'h3d) two = K_EQ;
                     else if (held_ff == 8'h21) two = K_NE;
                     else if (held_ff == 8'h3e) two = K_GE;
                     else if (held_ff == 8'h3c) two = K_LE;
                  end else if (b == 8'h26 && held_ff == 8'h26) begin
                     two = K_AND;
                  end else if (b == 8'h7c && held_ff == 8'h7c) begin
                     two = K_OR;
                  end
               end
               a_v     = 1'b1;
               mode_in = M_IDLE;
               priority if (two != K_NONE) begin
                  tok_a = make_tok(two, E_NONE, '0, line24);
               end else if (held_ff == 8'h3d) begin
                  tok_a = make_tok(K_ASSIGN, E_NONE, '0, line24);
                  fall  = 1'b1;
               end else if (held_ff == 8'h3e) begin
                  tok_a = make_tok(K_GT, E_NONE, '0, line24);
                  fall  = 1'b1;
               end else if (held_ff == 8'h3c) begin
                  tok_a = make_tok(K_LT, E_NONE, '0, line24);
                  fall  = 1'b1;
               end else begin
                  // lone bang, ampersand or bar
                  tok_a   = make_tok(K_ERR, E_CHAR, {24'd0, held_ff}, line24);
                  halt_in = 1'b1;
               end
            end
            default: begin
               fall = 1'b1;
            end
         endcase

         if (fall) begin
            mode_in = M_IDLE;
            priority if (endf) begin
               b_v      = 1'b1;
               tok_b    = make_tok(K_END, E_NONE, '0, line24);
               acc_in   = '0;
               count_in = '0;
            end else if (b == 8'h20 || b == 8'h09 || b == 8'h0d) begin
               b_v = 1'b0;
            end else if (b == 8'h0a) begin
               line_inc = 1'b1;
            end else if (is_alpha(b)) begin
               st_we    = 1'b1;
               st_addr  = '0;
               count_in = CNT_W'(1);
               mode_in  = M_IDENT;
            end else if (b == 8'h30) begin
               acc_in  = '0;
               mode_in = M_ZERO;
            end else if (is_digit(b)) begin
               acc_in  = VALUE_BITS'(b - 8'h30);
               mode_in = M_DEC;
            end else if (b == 8'h27) begin
               mode_in = M_CQ1;
            end else if (b == 8'h2f) begin
               mode_in = M_SLASH;
            end else if (sk != K_NONE) begin
               b_v   = 1'b1;
               tok_b = make_tok(sk, E_NONE, '0, line24);
            end else if (b == 8'h3d || b == 8'h21 || b == 8'h3c || b == 8'h3e ||
                         b == 8'h26 || b == 8'h7c) begin
               held_in = b;
               mode_in = M_OP2;
            end else begin
               b_v     = 1'b1;
               tok_b   = make_tok(K_ERR, E_CHAR, {24'd0, b}, line24);
               halt_in = 1'b1;
            end
         end
      end

      // saturating line counter
      line_in = line_ff;
      if (line_inc && line_ff != '1) begin
         line_in = line_ff + 1'b1;
      end

      // mark the final token of this request and pack the pushes
      tok_a.last = !b_v;
      tok_b.last = 1'b1;
      push0  = a_v ? tok_a : tok_b;
      push1  = tok_b;
      push_n = {1'b0, a_v} + {1'b0, b_v};
   end

   // Queue pointers.
   always_comb begin
      logic [1:0] n;
      n       = accept ? push_n : 2'd0;
      wr_in   = wr_ff + PTR_W'(n);
      rd_in   = rd_ff + PTR_W'(pop);
      qcnt_in = qcnt_ff + QCNT_W'(n) - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= M_IDLE;
         held_ff <= '0;
         count_ff <= '0;
         acc_ff  <= '0;
         line_ff <= LINE_BITS'(1);
         halt_ff <= 1'b0;
         wr_ff   <= '0;
         rd_ff   <= '0;
         qcnt_ff <= '0;
      end else begin
         // advance scanner state only on an accepted request
         if (accept) begin
            mode_ff  <= mode_in;
            held_ff  <= held_in;
            count_ff <= count_in;
            acc_ff   <= acc_in;
            line_ff  <= line_in;
            halt_ff  <= halt_in;
         end
         wr_ff   <= wr_in;
         rd_ff   <= rd_in;
         qcnt_ff <= qcnt_in;
      end
   end

   // Name store and queue payload: no reset.
   always_ff @(posedge clock) begin
      if (accept && st_we) begin
         store_ff[st_addr] <= b;
      end
      if (accept && push_n != 2'd0) begin
         q_ff[wr_ff] <= push0;
      end
      if (accept && push_n == 2'd2) begin
         q_ff[wr_ff + PTR_W'(1)] <= push1;
      end
   end

   `CST_ASSERT(a_qcnt_bound, qcnt_ff <= QCNT_W'(OUT_DEPTH), "token queue overflow")
   `CST_ASSERT(a_halt_silent, !(accept && halt_ff) || push_n == 2'd0, "token after error")
   `CST_ASSERT_NEXT(a_halt_sticky, halt_ff, halt_ff, "halt cleared without reset")
   `CST_ASSERT(a_line_nonzero, line_ff != '0, "line counter reached zero")

endmodule
